@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ROFS_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define ROFS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/rofs_pkg.sv @@
// Shared types, codes and helpers of the resting order fill simulator.
package rofs_pkg;

    localparam int DEF_ORDER_SLOTS     = 16;
    localparam int DEF_ENTRY_FRAC_BITS = 16;

    localparam logic [1:0] ACT_PLACE  = 2'd0;
    localparam logic [1:0] ACT_MARKET = 2'd1;
    localparam logic [1:0] ACT_CANCEL = 2'd2;
    localparam logic [1:0] ACT_UPDATE = 2'd3;

    localparam int POS_W   = 48;
    localparam int ENTRY_W = 56;
    localparam int TOT_W   = POS_W + 1;
    localparam int ACC_W   = 105;
    localparam int MAX_FILLS = 16;

    typedef struct packed {
        logic        buy;
        logic [31:0] qty;
        logic [31:0] executed;
        logic [39:0] price;
        logic [31:0] exch_id;
    } slot_entry_t;

    typedef struct packed {
        logic [POS_W-1:0]   ap;
        logic [ENTRY_W-1:0] ent;
        logic [31:0]        qty;
        logic [ENTRY_W-1:0] pq;
    } avg_req_t;

    // Price in ticks to fixed-point entry price, saturating.
    function automatic logic [ENTRY_W-1:0] to_entry(input logic [39:0] price,
                                                    input int frac);
        logic [63:0] w;
        w = {24'b0, price} << frac;
        return (|w[63:ENTRY_W]) ? {ENTRY_W{1'b1}} : w[ENTRY_W-1:0];
    endfunction

endpackage

@@ rtl/core/rofs_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module rofs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                 aclk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic                                 re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

@@ rtl/core/rofs_avg.sv @@
// Iterative weighted-average unit: shift-add products, then restoring division.
module rofs_avg
    import rofs_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  avg_req_t           req,
    output logic               done,
    output logic [ENTRY_W-1:0] result
);
    typedef enum logic [1:0] {P_IDLE, P_MUL1, P_MUL2, P_DIV} phase_t;

    phase_t             phase_reg;
    logic [ACC_W-1:0]   acc_reg;
    logic [ACC_W-1:0]   mcand_reg;
    logic [POS_W-1:0]   mplier_reg;
    logic [31:0]        qty_reg;
    logic [ENTRY_W-1:0] pq_reg;
    logic [TOT_W-1:0]   tot_reg;
    logic [TOT_W-1:0]   rem_reg;
    logic [ENTRY_W:0]   quot_reg;
    logic               ovf_reg;
    logic [6:0]         cnt_reg;
    logic               done_reg;

    logic [TOT_W-1:0]   tot_next;
    logic [TOT_W:0]     r2;
    logic               ge;
    logic [TOT_W:0]     diff;

    assign tot_next = {1'b0, req.ap} + {17'b0, req.qty};
    assign r2       = {rem_reg, acc_reg[ACC_W-1]};
    assign ge       = r2 >= {1'b0, tot_reg};
    assign diff     = r2 - {1'b0, tot_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= P_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= (phase_reg == P_DIV) && (cnt_reg == 7'(ACC_W - 1));
            case (phase_reg)
                P_IDLE: begin
                    if (start) begin
                        acc_reg    <= ACC_W'(tot_next >> 1);
                        mcand_reg  <= ACC_W'(req.ent);
                        mplier_reg <= req.ap;
                        qty_reg    <= req.qty;
                        pq_reg     <= req.pq;
                        tot_reg    <= tot_next;
                        cnt_reg    <= '0;
                        phase_reg  <= P_MUL1;
                    end
                end
                P_MUL1, P_MUL2: begin
                    if (mplier_reg[0]) begin
                        acc_reg <= acc_reg + mcand_reg;
                    end
                    if (phase_reg == P_MUL1 && cnt_reg == 7'(POS_W - 1)) begin
                        mcand_reg  <= ACC_W'(pq_reg);
                        mplier_reg <= POS_W'(qty_reg);
                        cnt_reg    <= '0;
                        phase_reg  <= P_MUL2;
                    end else begin
                        mcand_reg  <= mcand_reg << 1;
                        mplier_reg <= mplier_reg >> 1;
                        if (phase_reg == P_MUL2 && cnt_reg == 7'd31) begin
                            rem_reg   <= '0;
                            quot_reg  <= '0;
                            ovf_reg   <= 1'b0;
                            cnt_reg   <= '0;
                            phase_reg <= P_DIV;
                        end else begin
                            cnt_reg <= cnt_reg + 7'd1;
                        end
                    end
                end
                P_DIV: begin
                    rem_reg  <= ge ? diff[TOT_W-1:0] : r2[TOT_W-1:0];
                    acc_reg  <= acc_reg << 1;
                    quot_reg <= {quot_reg[ENTRY_W-1:0], ge};
                    ovf_reg  <= ovf_reg | quot_reg[ENTRY_W];
                    cnt_reg  <= cnt_reg + 7'd1;
                    if (cnt_reg == 7'(ACC_W - 1)) begin
                        phase_reg <= P_IDLE;
                    end
                end
                default: phase_reg <= P_IDLE;
            endcase
        end
    end

    assign done   = done_reg;
    assign result = (ovf_reg || quot_reg[ENTRY_W]) ? {ENTRY_W{1'b1}} : quot_reg[ENTRY_W-1:0];
endmodule

@@ rtl/core/resting_order_fill_simulator.sv @@
// Resting order fill simulator: slot table in one RAM, walk of slots against the last
// best bid/ask, net position and average entry tracking. One request is handled at a
// time; s_ready is high only while idle. A place or an update walks the slots unless
// either side of the book is empty. A fill from the walk or from a market order that
// adds to the position on the same side waits for the average unit, with its
// bit-serial multiply (48 + 32 steps) and 105-step divide.
// Closing words can wait in the output register while the next request is taken.
module resting_order_fill_simulator
    import rofs_pkg::*;
#(
    parameter int ORDER_SLOTS     = DEF_ORDER_SLOTS,
    parameter int ENTRY_FRAC_BITS = DEF_ENTRY_FRAC_BITS
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [1:0]               s_action,
    input  logic [3:0]               s_order_slot,
    input  logic                     s_buy_side,
    input  logic [31:0]              s_order_qty,
    input  logic [39:0]              s_order_price,
    input  logic [39:0]              s_best_bid,
    input  logic [39:0]              s_best_ask,
    input  logic [31:0]              s_bid_size,
    input  logic [31:0]              s_ask_size,
    input  logic [63:0]              s_event_time,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic                     m_ack_ok,
    output logic [31:0]              m_exchange_id,
    output logic                     m_fill_flag,
    output logic [3:0]               m_fill_slot,
    output logic                     m_fill_buy,
    output logic [39:0]              m_fill_price,
    output logic [31:0]              m_fill_qty,
    output logic [63:0]              m_fill_time,
    output logic signed [POS_W-1:0]  m_net_position,
    output logic [ENTRY_W-1:0]       m_avg_entry,
    output logic                     m_last_item
);
    localparam int SLOT_W  = (ORDER_SLOTS > 1) ? $clog2(ORDER_SLOTS) : 1;
    localparam int ENTRY_BITS = $bits(slot_entry_t);

    typedef enum logic [3:0] {
        S_IDLE, S_CANCEL_RD, S_WALK_START, S_WALK, S_WALK_EVAL,
        S_APPLY, S_AVG, S_EMIT, S_CLOSE
    } state_t;

    state_t                  state_reg;
    logic [ORDER_SLOTS-1:0]  slot_valid_reg;
    logic [31:0]             id_counter_reg;
    logic [39:0]             book_bid_reg, book_ask_reg;
    logic [31:0]             book_bid_size_reg, book_ask_size_reg;
    logic [63:0]             book_time_reg;
    logic signed [POS_W-1:0] position_reg;
    logic [ENTRY_W-1:0]      entry_reg;
    logic [SLOT_W-1:0]       walk_idx_reg;
    logic                    req_ack_reg;
    logic [31:0]             req_id_reg;
    logic [3:0]              fill_slot_reg;
    logic                    fill_buy_reg;
    logic [39:0]             fill_price_reg;
    logic [31:0]             fill_qty_reg;
    logic [31:0]             fill_id_reg;
    logic                    from_walk_reg;
    logic [4:0]              fill_cnt_reg;

    logic                    m_valid_reg, m_ack_ok_reg, m_fill_flag_reg;
    logic                    m_fill_buy_reg, m_last_item_reg;
    logic [31:0]             m_exchange_id_reg, m_fill_qty_reg;
    logic [3:0]              m_fill_slot_reg;
    logic [39:0]             m_fill_price_reg;
    logic [63:0]             m_fill_time_reg;
    logic signed [POS_W-1:0] m_net_position_reg;
    logic [ENTRY_W-1:0]      m_avg_entry_reg;

    // Slot index and range check of the incoming word.
    logic [SLOT_W+3:0]       in_slot_ext;
    logic [SLOT_W-1:0]       in_idx;
    logic                    in_range;
    logic [31:0]             id_next;
    logic [39:0]             mkt_px;
    logic                    mkt_reject;

    assign in_slot_ext = {{SLOT_W{1'b0}}, s_order_slot};
    assign in_idx      = in_slot_ext[SLOT_W-1:0];
    assign in_range    = 32'(s_order_slot) < ORDER_SLOTS;
    assign id_next     = (id_counter_reg == 32'hFFFF_FFFF) ? 32'd1 : id_counter_reg + 32'd1;
    assign mkt_px      = s_buy_side ? book_ask_reg : book_bid_reg;
    assign mkt_reject  = (mkt_px == '0) || (s_order_qty == '0);
    assign s_ready     = (state_reg == S_IDLE);

    // Slot RAM.
    logic                    ram_we, ram_re;
    logic [SLOT_W-1:0]       ram_waddr, ram_raddr;
    slot_entry_t             ram_wentry, rd_entry;
    logic [ENTRY_BITS-1:0]   ram_rdata;

    assign rd_entry = slot_entry_t'(ram_rdata);

    // Walk evaluation on the read-back entry.
    logic        ev_done, ev_cross, ev_take;
    logic [31:0] ev_rem, ev_avail, ev_fill, ev_exec_new;
    logic [SLOT_W+3:0] walk_idx_ext;
    logic        walk_last;

    assign ev_done      = rd_entry.executed >= rd_entry.qty;
    assign ev_rem       = rd_entry.qty - rd_entry.executed;
    assign ev_cross     = rd_entry.buy ? (book_ask_reg <= rd_entry.price)
                                       : (book_bid_reg >= rd_entry.price);
    assign ev_avail     = rd_entry.buy ? book_ask_size_reg : book_bid_size_reg;
    assign ev_fill      = (ev_rem < ev_avail) ? ev_rem : ev_avail;
    assign ev_take      = !ev_done && ev_cross && (ev_fill != 32'd0);
    assign ev_exec_new  = rd_entry.executed + ev_fill;
    assign walk_idx_ext = {4'b0, walk_idx_reg};
    assign walk_last    = walk_idx_reg == SLOT_W'(ORDER_SLOTS - 1);

    always_comb begin
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        ram_waddr  = walk_idx_reg;
        ram_raddr  = walk_idx_reg;
        ram_wentry = rd_entry;
        ram_wentry.executed = ev_exec_new;
        if (state_reg == S_IDLE) begin
            ram_waddr = in_idx;
            ram_raddr = in_idx;
            ram_wentry.buy      = s_buy_side;
            ram_wentry.qty      = s_order_qty;
            ram_wentry.executed = '0;
            ram_wentry.price    = s_order_price;
            ram_wentry.exch_id  = id_counter_reg;
            ram_we = s_valid && (s_action == ACT_PLACE) && in_range;
            ram_re = s_valid && (s_action == ACT_CANCEL) && in_range
                     && slot_valid_reg[in_idx];
        end else if (state_reg == S_WALK) begin
            ram_re = slot_valid_reg[walk_idx_reg];
        end else if (state_reg == S_WALK_EVAL) begin
            ram_we = ev_take;
        end
    end

    rofs_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (ORDER_SLOTS)
    ) u_slot_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wentry),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Position update of one fill.
    logic [ENTRY_W-1:0]      pq;
    logic signed [POS_W:0]   np_wide;
    logic signed [POS_W-1:0] np_sat;
    logic                    pos_zero, pos_pos, np_pos, same_side, flip;
    logic [POS_W-1:0]        pos_mag;

    assign pq      = to_entry(fill_price_reg, ENTRY_FRAC_BITS);
    assign np_wide = fill_buy_reg
                     ? {position_reg[POS_W-1], position_reg} + {17'b0, fill_qty_reg}
                     : {position_reg[POS_W-1], position_reg} - {17'b0, fill_qty_reg};
    always_comb begin
        if (!np_wide[POS_W] && np_wide[POS_W-1]) begin
            np_sat = {1'b0, {(POS_W-1){1'b1}}};
        end else if (np_wide[POS_W] && !np_wide[POS_W-1]) begin
            np_sat = {1'b1, {(POS_W-1){1'b0}}};
        end else begin
            np_sat = np_wide[POS_W-1:0];
        end
    end
    assign pos_zero  = position_reg == '0;
    assign pos_pos   = !position_reg[POS_W-1] && !pos_zero;
    assign np_pos    = !np_sat[POS_W-1] && (np_sat != '0);
    assign same_side = !pos_zero && (pos_pos == fill_buy_reg);
    assign flip      = (np_sat != '0) && (pos_pos != np_pos);
    assign pos_mag   = position_reg[POS_W-1] ? POS_W'(-position_reg) : POS_W'(position_reg);

    avg_req_t           avg_req;
    logic               avg_start, avg_done;
    logic [ENTRY_W-1:0] avg_result;

    assign avg_req.ap  = pos_mag;
    assign avg_req.ent = entry_reg;
    assign avg_req.qty = fill_qty_reg;
    assign avg_req.pq  = pq;
    assign avg_start   = (state_reg == S_APPLY) && !pos_zero && same_side;

    rofs_avg u_avg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (avg_start),
        .req     (avg_req),
        .done    (avg_done),
        .result  (avg_result)
    );

    logic out_free, out_load;
    assign out_free = !m_valid_reg || m_ready;
    assign out_load = out_free && ((state_reg == S_CLOSE) ||
                      (state_reg == S_EMIT && fill_cnt_reg < 5'(MAX_FILLS)));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= S_IDLE;
            slot_valid_reg    <= '0;
            id_counter_reg    <= 32'd1;
            book_bid_reg      <= '0;
            book_ask_reg      <= '0;
            book_bid_size_reg <= '0;
            book_ask_size_reg <= '0;
            book_time_reg     <= '0;
            position_reg      <= '0;
            entry_reg         <= '0;
            m_valid_reg       <= 1'b0;
            fill_cnt_reg      <= '0;
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        fill_cnt_reg <= '0;
                        req_ack_reg  <= !((s_action == ACT_MARKET) && mkt_reject);
                        case (s_action)
                            ACT_PLACE: begin
                                req_id_reg     <= id_counter_reg;
                                id_counter_reg <= id_next;
                                if (in_range) begin
                                    slot_valid_reg[in_idx] <= 1'b1;
                                end
                                state_reg <= S_WALK_START;
                            end
                            ACT_MARKET: begin
                                req_id_reg     <= id_counter_reg;
                                id_counter_reg <= id_next;
                                fill_slot_reg  <= s_order_slot;
                                fill_buy_reg   <= s_buy_side;
                                fill_price_reg <= mkt_px;
                                fill_qty_reg   <= s_order_qty;
                                fill_id_reg    <= id_counter_reg;
                                from_walk_reg  <= 1'b0;
                                state_reg      <= mkt_reject ? S_CLOSE : S_APPLY;
                            end
                            ACT_CANCEL: begin
                                req_id_reg <= '0;
                                if (in_range && slot_valid_reg[in_idx]) begin
                                    slot_valid_reg[in_idx] <= 1'b0;
                                    state_reg <= S_CANCEL_RD;
                                end else begin
                                    state_reg <= S_CLOSE;
                                end
                            end
                            default: begin
                                book_bid_reg      <= s_best_bid;
                                book_ask_reg      <= s_best_ask;
                                book_bid_size_reg <= s_bid_size;
                                book_ask_size_reg <= s_ask_size;
                                book_time_reg     <= s_event_time;
                                req_id_reg        <= '0;
                                state_reg         <= S_WALK_START;
                            end
                        endcase
                    end
                end
                S_CANCEL_RD: begin
                    req_id_reg <= rd_entry.exch_id;
                    state_reg  <= S_CLOSE;
                end
                S_WALK_START: begin
                    walk_idx_reg <= '0;
                    // skip the walk while either side of the book is empty
                    state_reg <= (book_bid_reg == '0 || book_ask_reg == '0) ? S_CLOSE : S_WALK;
                end
                S_WALK: begin
                    if (slot_valid_reg[walk_idx_reg]) begin
                        state_reg <= S_WALK_EVAL;
                    end else begin
                        walk_idx_reg <= walk_idx_reg + SLOT_W'(1);
                        state_reg    <= walk_last ? S_CLOSE : S_WALK;
                    end
                end
                S_WALK_EVAL: begin
                    if (ev_take) begin
                        fill_slot_reg  <= walk_idx_ext[3:0];
                        fill_buy_reg   <= rd_entry.buy;
                        fill_price_reg <= rd_entry.price;
                        fill_qty_reg   <= ev_fill;
                        fill_id_reg    <= rd_entry.exch_id;
                        from_walk_reg  <= 1'b1;
                        if (ev_exec_new >= rd_entry.qty) begin
                            slot_valid_reg[walk_idx_reg] <= 1'b0;
                        end
                        state_reg <= S_APPLY;
                    end else begin
                        // free an exhausted slot
                        if (ev_done) begin
                            slot_valid_reg[walk_idx_reg] <= 1'b0;
                        end
                        walk_idx_reg <= walk_idx_reg + SLOT_W'(1);
                        state_reg    <= walk_last ? S_CLOSE : S_WALK;
                    end
                end
                S_APPLY: begin
                    position_reg <= np_sat;
                    if (pos_zero) begin
                        entry_reg <= pq;
                        state_reg <= S_EMIT;
                    end else if (same_side) begin
                        state_reg <= S_AVG;
                    end else begin
                        if (flip) begin
                            entry_reg <= pq;
                        end
                        state_reg <= S_EMIT;
                    end
                end
                S_AVG: begin
                    if (avg_done) begin
                        entry_reg <= avg_result;
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (fill_cnt_reg >= 5'(MAX_FILLS) || out_free) begin
                        if (fill_cnt_reg < 5'(MAX_FILLS)) begin
                            m_ack_ok_reg       <= 1'b1;
                            m_exchange_id_reg  <= fill_id_reg;
                            m_fill_flag_reg    <= 1'b1;
                            m_fill_slot_reg    <= fill_slot_reg;
                            m_fill_buy_reg     <= fill_buy_reg;
                            m_fill_price_reg   <= fill_price_reg;
                            m_fill_qty_reg     <= fill_qty_reg;
                            m_fill_time_reg    <= book_time_reg;
                            m_net_position_reg <= position_reg;
                            m_avg_entry_reg    <= pos_zero ? '0 : entry_reg;
                            m_last_item_reg    <= 1'b0;
                            fill_cnt_reg       <= fill_cnt_reg + 5'd1;
                        end
                        if (from_walk_reg) begin
                            walk_idx_reg <= walk_idx_reg + SLOT_W'(1);
                            state_reg    <= walk_last ? S_CLOSE : S_WALK;
                        end else begin
                            state_reg <= S_CLOSE;
                        end
                    end
                end
                S_CLOSE: begin
                    if (out_free) begin
                        m_ack_ok_reg       <= req_ack_reg;
                        m_exchange_id_reg  <= req_id_reg;
                        m_fill_flag_reg    <= 1'b0;
                        m_fill_slot_reg    <= '0;
                        m_fill_buy_reg     <= 1'b0;
                        m_fill_price_reg   <= '0;
                        m_fill_qty_reg     <= '0;
                        m_fill_time_reg    <= '0;
                        m_net_position_reg <= position_reg;
                        m_avg_entry_reg    <= pos_zero ? '0 : entry_reg;
                        m_last_item_reg    <= 1'b1;
                        state_reg          <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_ack_ok       = m_ack_ok_reg;
    assign m_exchange_id  = m_exchange_id_reg;
    assign m_fill_flag    = m_fill_flag_reg;
    assign m_fill_slot    = m_fill_slot_reg;
    assign m_fill_buy     = m_fill_buy_reg;
    assign m_fill_price   = m_fill_price_reg;
    assign m_fill_qty     = m_fill_qty_reg;
    assign m_fill_time    = m_fill_time_reg;
    assign m_net_position = m_net_position_reg;
    assign m_avg_entry    = m_avg_entry_reg;
    assign m_last_item    = m_last_item_reg;
endmodule

@@ rtl/core/rofs_checker.sv @@
// Port-level checker of the resting order fill simulator, bound to the top level.
`include "assert_macros.svh"

module rofs_checker
    import rofs_pkg::*;
(
    input logic                     aclk,
    input logic                     aresetn,
    input logic                     s_valid,
    input logic                     s_ready,
    input logic [1:0]               s_action,
    input logic [3:0]               s_order_slot,
    input logic                     s_buy_side,
    input logic [31:0]              s_order_qty,
    input logic [39:0]              s_order_price,
    input logic [39:0]              s_best_bid,
    input logic [39:0]              s_best_ask,
    input logic [31:0]              s_bid_size,
    input logic [31:0]              s_ask_size,
    input logic [63:0]              s_event_time,
    input logic                     m_valid,
    input logic                     m_ready,
    input logic                     m_ack_ok,
    input logic [31:0]              m_exchange_id,
    input logic                     m_fill_flag,
    input logic [3:0]               m_fill_slot,
    input logic                     m_fill_buy,
    input logic [39:0]              m_fill_price,
    input logic [31:0]              m_fill_qty,
    input logic [63:0]              m_fill_time,
    input logic signed [POS_W-1:0]  m_net_position,
    input logic [ENTRY_W-1:0]       m_avg_entry,
    input logic                     m_last_item
);
    logic [286:0] s_word;
    logic         fill_ok, close_ok;

    assign s_word   = {s_action, s_order_slot, s_buy_side, s_order_qty, s_order_price,
                       s_best_bid, s_best_ask, s_bid_size, s_ask_size, s_event_time};
    assign fill_ok  = m_ack_ok && !m_last_item && (m_fill_qty != 32'd0)
                      && (m_exchange_id != 32'd0);
    assign close_ok = m_last_item && (m_fill_qty == 32'd0) && (m_fill_slot == 4'd0)
                      && !m_fill_buy && (m_fill_price == 40'd0) && (m_fill_time == 64'd0);

    `ROFS_ASSERT_NEXT(a_in_hold, aclk, aresetn, s_valid && !s_ready, s_valid && $stable(s_word), "input word changed while waiting")
    `ROFS_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid, "output word dropped while stalled")
    `ROFS_ASSERT_SAME(a_fill_ack, aclk, aresetn, m_valid && m_fill_flag, fill_ok, "fill word malformed")
    `ROFS_ASSERT_SAME(a_close_kind, aclk, aresetn, m_valid && !m_fill_flag, close_ok, "non-fill word is not a closing word")
    `ROFS_ASSERT_SAME(a_flat_entry, aclk, aresetn, m_valid && m_net_position == '0, m_avg_entry == '0, "entry reported while flat")
endmodule

bind resting_order_fill_simulator rofs_checker u_rofs_checker (.*);
